[rtl/core/ordered_list_table_core_assert.svh]
// ---------------------------------------------------------------------------
// ordered list table assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ---------------------------------------------------------------------------
`ifndef ORDERED_LIST_TABLE_CORE_ASSERT_SVH
`define ORDERED_LIST_TABLE_CORE_ASSERT_SVH

// property holds at every edge outside reset
`define OLT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// when cond holds, res holds in the next cycle
`define OLT_ASSERT_NEXT(label, cond, res, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (res)) \
    else $error(msg);

`endif

[rtl/core/olt_pkg.sv]
// ---------------------------------------------------------------------------
// ordered list table package
// request and status codes, cell control and scan token types
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package olt_pkg;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_GET    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_FIND   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  localparam logic [6:0] NONE_INDEX = 7'h7F;

  // one-cycle write commands plus the kind of scan in flight
  typedef struct packed {
    logic append;
    logic remove;
    logic clear;
    logic is_get;
  } cell_ctrl_t;

  // scan token walking down the chain
  typedef struct packed {
    logic        valid;
    logic        found;
    logic [6:0]  hit_idx;
    logic [31:0] rd;
  } tok_t;

endpackage

[rtl/core/ordered_list_table_core.sv]
// ---------------------------------------------------------------------------
// ordered list table core
// fixed-capacity ordered list built as a chain of entry cells
// ---------------------------------------------------------------------------
// Requests arrive on the input channel (in_valid_i / in_stall_o) as one beat
// of operation, index and value; each request gives one result beat on the
// output channel (out_valid_o / out_stall_i) with status, read value, found
// index and the entry count after the request.
// Append, remove, clear and unused codes act on all cells in parallel and
// their result is in the output register in the cycle after the beat is taken.
// Get and find launch a token that walks the cell chain one cell per cycle
// while the end of the chain is not held; their result is registered after it.
// One request is in flight at a time: a mutating request may follow every
// cycle while the output is not stalled, a get or find holds the input for the length of the chain walk.
// The next beat is taken while a result waits, as long as the output
// register frees in the same cycle.
// Reset clears every entry and the count at once; no clearing pass.
// While the receiver stalls the result register holds, the token at the end
// of the chain waits, and no new request is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_list_table_core #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         operation_i,
  input  logic [5:0]         index_i,
  input  logic [31:0]        value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [31:0]        read_value_o,
  output logic signed [6:0]  found_index_o,
  output logic [6:0]         count_o
);
  import olt_pkg::*;

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > 6) ? CW : 6;
  localparam int unsigned VW   = VALUE_WIDTH;

  logic                 busy_q, out_valid_q;
  logic [CW-1:0]        count_q, count_d;
  logic                 q_get_q;
  logic [VW-1:0]        q_val_q;
  logic [5:0]           q_idx_q;
  logic [1:0]           status_q;
  logic [31:0]          rd_q;
  logic [6:0]           found_q, cnt_out_q;

  logic                 accept, start, full, idx_ok, out_free, adv;
  logic [VW+31:0]       vext;
  logic [VW-1:0]        val_in, cell_val;
  logic [5:0]           cell_idx;
  logic [CW+6:0]        cnt_ext;
  status_e              st, q_st;
  logic [31:0]          q_rd;
  logic [6:0]           q_fi;
  cell_ctrl_t           ctrl;
  tok_t                 tok [0:CAPACITY];
  logic [VW-1:0]        entry_w [0:CAPACITY-1];

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign adv      = !tok[CAPACITY].valid || out_free;
  assign in_stall_o = busy_q || (out_valid_q && out_stall_i);

  assign vext     = {{VW{1'b0}}, value_i};
  assign val_in   = vext[VW-1:0];
  assign full     = count_q == CW'(CAPACITY);
  assign idx_ok   = CMPW'(index_i) < CMPW'(count_q);
  assign cell_val = busy_q ? q_val_q : val_in;
  assign cell_idx = busy_q ? q_idx_q : index_i;

  // request decode
  always_comb begin
    ctrl        = '0;
    ctrl.is_get = busy_q ? q_get_q : (operation_i == OP_GET);
    count_d     = count_q;
    st          = ST_OK;
    start       = 1'b0;
    if (accept) begin
      unique case (op_e'(operation_i))
        OP_APPEND: begin
          if (full) begin
            st = ST_FULL;
          end else begin
            ctrl.append = 1'b1;
            count_d     = count_q + 1'b1;
          end
        end
        OP_GET:  start = 1'b1;
        OP_REMOVE: begin
          if (!idx_ok) begin
            st = ST_RANGE;
          end else begin
            ctrl.remove = 1'b1;
            count_d     = count_q - 1'b1;
          end
        end
        OP_FIND: start = 1'b1;
        OP_CLEAR: begin
          ctrl.clear = 1'b1;
          count_d    = '0;
        end
        default: ;
      endcase
    end
    cnt_ext = {7'b0, count_d};
  end

  assign tok[0] = '{valid: start, found: 1'b0, hit_idx: 7'b0, rd: 32'b0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VW-1:0] nbr;
    if (i == CAPACITY - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = entry_w[i+1];
    end

    olt_cell #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX         (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .adv_i   (adv),
      .idx_i   (cell_idx),
      .count_i (count_q),
      .val_i   (cell_val),
      .nbr_i   (nbr),
      .tok_i   (tok[i]),
      .entry_o (entry_w[i]),
      .tok_o   (tok[i+1])
    );
  end

  // scan result at the end of the chain
  always_comb begin
    q_st = (q_get_q && !tok[CAPACITY].found) ? ST_RANGE : ST_OK;
    q_rd = (q_get_q && tok[CAPACITY].found) ? tok[CAPACITY].rd : 32'b0;
    q_fi = (!q_get_q && tok[CAPACITY].found) ? tok[CAPACITY].hit_idx : NONE_INDEX;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      count_q <= count_d;
      if (accept && !start) begin
        out_valid_q <= 1'b1;
      end else if (tok[CAPACITY].valid && out_free) begin
        out_valid_q <= 1'b1;
        busy_q      <= 1'b0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (start) begin
        busy_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_get_q <= operation_i == OP_GET;
      q_val_q <= val_in;
      q_idx_q <= index_i;
    end
    if (accept && !start) begin
      status_q  <= st;
      rd_q      <= 32'b0;
      found_q   <= NONE_INDEX;
      cnt_out_q <= cnt_ext[6:0];
    end else if (tok[CAPACITY].valid && out_free) begin
      status_q  <= q_st;
      rd_q      <= q_rd;
      found_q   <= q_fi;
      cnt_out_q <= cnt_ext[6:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign read_value_o  = rd_q;
  assign found_index_o = $signed(found_q);
  assign count_o       = cnt_out_q;

endmodule

[rtl/core/olt_cell.sv]
// ---------------------------------------------------------------------------
// ordered list table cell
// holds one entry, takes writes and shifts, updates the passing scan token
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module olt_cell #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned IDX         = 0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  olt_pkg::cell_ctrl_t                ctrl_i,
  input  logic                               adv_i,
  input  logic [5:0]                         idx_i,
  input  logic [$clog2(CAPACITY+1)-1:0]      count_i,
  input  logic [VALUE_WIDTH-1:0]             val_i,
  input  logic [VALUE_WIDTH-1:0]             nbr_i,
  input  olt_pkg::tok_t                      tok_i,
  output logic [VALUE_WIDTH-1:0]             entry_o,
  output olt_pkg::tok_t                      tok_o
);
  import olt_pkg::*;

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > 6) ? CW : 6;

  logic [VALUE_WIDTH-1:0]    entry_q, entry_d;
  tok_t                      tok_q, tok_d;
  logic [CMPW-1:0]           my_idx, idx_x, cnt_x;
  logic                      in_list, hit;
  logic [VALUE_WIDTH+31:0]   rd_ext;

  always_comb begin
    my_idx  = CMPW'(IDX);
    idx_x   = CMPW'(idx_i);
    cnt_x   = CMPW'(count_i);
    in_list = my_idx < cnt_x;
    hit     = ctrl_i.is_get ? (in_list && (idx_x == my_idx))
                            : (in_list && (entry_q == val_i));
    rd_ext  = {32'b0, entry_q};

    tok_d = tok_i;
    if (tok_i.valid && !tok_i.found && hit) begin
      tok_d.found   = 1'b1;
      tok_d.hit_idx = 7'(IDX);
      tok_d.rd      = rd_ext[31:0];
    end

    // slots past the count are always zero, so a remove shifts everything above
    entry_d = entry_q;
    if (ctrl_i.clear) begin
      entry_d = '0;
    end else if (ctrl_i.append && (my_idx == cnt_x)) begin
      entry_d = val_i;
    end else if (ctrl_i.remove && (my_idx >= idx_x)) begin
      entry_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      tok_q   <= '0;
    end else begin
      entry_q <= entry_d;
      if (adv_i) begin
        tok_q <= tok_d;
      end
    end
  end

  assign entry_o = entry_q;
  assign tok_o   = tok_q;

endmodule

[rtl/core/olt_checker.sv]
// ---------------------------------------------------------------------------
// ordered list table checker
// port-level assertions on result beats, bound to the core
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ordered_list_table_core_assert.svh"

module olt_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic [2:0]         operation_i,
  input  logic [5:0]         index_i,
  input  logic [31:0]        value_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic [1:0]         status_o,
  input  logic [31:0]        read_value_o,
  input  logic signed [6:0]  found_index_o,
  input  logic [6:0]         count_o
);
  import olt_pkg::*;

  // a result beat waits while the receiver stalls
  `OLT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result beat dropped")

  `OLT_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(status_o) && $stable(count_o) && $stable(read_value_o), "stalled result changed")

  // a rejected append reports nothing but its status and count
  `OLT_ASSERT(a_full_clean, !(out_valid_o && (status_o == ST_FULL)) || ((found_index_o == -7'sd1) && (read_value_o == 32'b0)), "full append carries data")

  // a read value only comes with a successful get
  `OLT_ASSERT(a_rd_ok, !(out_valid_o && (read_value_o != 32'b0)) || ((status_o == ST_OK) && (found_index_o == -7'sd1)), "read value on a non-get result")

endmodule

bind ordered_list_table_core olt_checker u_olt_checker (.*);

[test/testbench.sv]
// ---------------------------------------------------------------------------
// ordered list table core testbench
// ---------------------------------------------------------------------------
// Sends append, get, remove, find, clear and unused requests. A shadow copy of
// the list predicts each response. Responses are checked in order against
// that prediction. Directed cases come first: empty list, value extremes,
// duplicates, unused codes, compaction and clear. Random traffic follows,
// made of fill, drain, clear and mixed episodes, with bursty input and a
// stall on the output that switches between random and patterned modes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import olt_pkg::*;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned VALUE_WIDTH = 32;

  // codes 5 to 7 are reserved and leave the list alone
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

  typedef struct packed {
    status_e     status;
    logic [31:0] read_value;
    logic [6:0]  found_index;
    logic [6:0]  count;
  } table_resp_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [2:0]         operation_i = OP_APPEND;
  logic [5:0]         index_i     = '0;
  logic [31:0]        value_i     = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic [31:0]        read_value_o;
  logic signed [6:0]  found_index_o;
  logic [6:0]         count_o;

  logic [31:0] shadow_entries [CAPACITY];
  int unsigned shadow_len = 0;
  table_resp_t pending_responses [$];
  int          mismatch_count = 0;
  int          burst_left = 0;
  logic [31:0] value_pool [4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001, 32'h0000_00A5};

  ordered_list_table_core #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .found_index_o(found_index_o),
    .count_o      (count_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    foreach (shadow_entries[k]) shadow_entries[k] = '0;
  end

  // applies one request to the shadow list and returns the response it gives
  function automatic table_resp_t predict_table_response(logic [2:0] op, logic [5:0] idx,
                                                         logic [31:0] val);
    table_resp_t resp;
    int unsigned i;
    resp.status      = ST_OK;
    resp.read_value  = '0;
    resp.found_index = NONE_INDEX;
    case (op)
      OP_APPEND: begin
        if (shadow_len >= CAPACITY) begin
          resp.status = ST_FULL;
        end else begin
          shadow_entries[shadow_len] = val;
          shadow_len++;
        end
      end
      OP_GET: begin
        if (idx >= shadow_len) resp.status = ST_RANGE;
        else resp.read_value = shadow_entries[idx];
      end
      OP_REMOVE: begin
        if (idx >= shadow_len) begin
          resp.status = ST_RANGE;
        end else begin
          for (i = idx; i + 1 < shadow_len; i++) shadow_entries[i] = shadow_entries[i + 1];
          shadow_entries[shadow_len - 1] = '0;
          shadow_len--;
        end
      end
      OP_FIND: begin
        for (i = 0; i < shadow_len && resp.found_index == NONE_INDEX; i++) begin
          if (shadow_entries[i] == val) resp.found_index = i[6:0];
        end
      end
      OP_CLEAR: begin
        foreach (shadow_entries[k]) shadow_entries[k] = '0;
        shadow_len = 0;
      end
      default: ;
    endcase
    resp.count = shadow_len[6:0];
    return resp;
  endfunction

  // sender paces itself in bursts; valid stays up across back-to-back beats
  task automatic send_request(input logic [2:0] op, input logic [5:0] idx,
                              input logic [31:0] val);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    operation_i <= op;
    index_i     <= idx;
    value_i     <= val;
    do @(posedge clk_i); while (in_stall_o);
    pending_responses.push_back(predict_table_response(op, idx, val));
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_responses.size() != 0);
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 3) == 0) return value_pool[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  function automatic logic [5:0] pick_index();
    if (shadow_len > 0 && $urandom_range(0, 4) != 0) return 6'($urandom_range(0, shadow_len - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  // output checker
  always @(posedge clk_i) begin
    table_resp_t exp_resp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_responses.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: unexpected beat: status %0d read %h found %0d count %0d", $realtime,
                   status_o, read_value_o, found_index_o, count_o);
        mismatch_count++;
      end else begin
        exp_resp = pending_responses.pop_front();
        if (status_o !== exp_resp.status || read_value_o !== exp_resp.read_value ||
            found_index_o !== exp_resp.found_index || count_o !== exp_resp.count) begin
          if (mismatch_count < 10)
            $display("%0t: mismatch: exp status %0d read %h found %0d count %0d, got status %0d read %h found %0d count %0d",
                     $realtime, exp_resp.status, exp_resp.read_value,
                     $signed(exp_resp.found_index), exp_resp.count,
                     status_o, read_value_o, found_index_o, count_o);
          mismatch_count++;
        end
      end
    end
  end

  // receiver stall: randomly chosen modes of no stall, random stall or a repeating pattern
  int stall_mode = 0;
  int stall_mode_left = 0;
  int stall_tick = 0;
  always @(posedge clk_i) begin
    if (stall_mode_left == 0) begin
      stall_mode      = $urandom_range(0, 3);
      stall_mode_left = $urandom_range(50, 300);
    end
    stall_mode_left--;
    stall_tick++;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= 1'($urandom_range(0, 1));
      default: out_stall_i <= ((stall_tick % 16) < 10);
    endcase
  end

  task automatic test_empty_list();
    send_request(OP_GET, 6'd0, 32'h0);
    send_request(OP_GET, 6'd63, 32'hFFFF_FFFF);
    send_request(OP_REMOVE, 6'd0, 32'h0);
    // entries are zero after reset but none is held
    send_request(OP_FIND, 6'd0, 32'h0);
    send_request(OP_CLEAR, 6'd63, 32'hFFFF_FFFF);
  endtask

  task automatic test_append_and_get();
    send_request(OP_APPEND, 6'd0, 32'h0000_0000);
    send_request(OP_APPEND, 6'd63, 32'hFFFF_FFFF);
    send_request(OP_APPEND, 6'd21, 32'hA5A5_5A5A);
    send_request(OP_APPEND, 6'd42, 32'hFFFF_FFFF);
    send_request(OP_GET, 6'd0, 32'h0);
    send_request(OP_GET, 6'd1, 32'h0);
    send_request(OP_GET, 6'd3, 32'hFFFF_FFFF);
    send_request(OP_GET, 6'd4, 32'h0);
  endtask

  task automatic test_unused_codes();
    int code;
    for (code = OP_FIRST_UNUSED; code <= OP_LAST_UNUSED; code++)
      send_request(3'(code), 6'd63, 32'hFFFF_FFFF);
  endtask

  task automatic test_find_lowest();
    send_request(OP_FIND, 6'd0, 32'hFFFF_FFFF);
    send_request(OP_FIND, 6'd63, 32'h0000_0000);
    send_request(OP_FIND, 6'd0, 32'h1234_5678);
  endtask

  task automatic test_remove_compaction();
    send_request(OP_REMOVE, 6'd1, 32'h0);
    send_request(OP_GET, 6'd2, 32'h0);
    send_request(OP_REMOVE, 6'd3, 32'h0);
    send_request(OP_REMOVE, 6'd2, 32'h0);
    send_request(OP_GET, 6'd2, 32'h0);
  endtask

  task automatic test_clear();
    send_request(OP_CLEAR, 6'd0, 32'h0);
    send_request(OP_GET, 6'd0, 32'h0);
  endtask

  task automatic test_random_traffic(input int target);
    int          sent;
    int          kind;
    int          roll;
    logic [2:0]  op;
    logic [31:0] val;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        // fill up, then push against the full list
        while (shadow_len < CAPACITY) begin
          send_request(OP_APPEND, 6'($urandom_range(0, 63)), pick_value());
          sent++;
        end
        repeat ($urandom_range(1, 3)) begin
          send_request(OP_APPEND, 6'($urandom_range(0, 63)), $urandom);
          sent++;
        end
        send_request(OP_GET, 6'd63, $urandom);
        send_request(OP_FIND, 6'($urandom_range(0, 63)), shadow_entries[CAPACITY - 1]);
        sent += 2;
      end else if (kind < 4) begin
        while (shadow_len > 0) begin
          send_request(OP_REMOVE, pick_index(), $urandom);
          sent++;
        end
        send_request(OP_REMOVE, 6'($urandom_range(0, 63)), $urandom);
        sent++;
      end else if (kind == 4) begin
        wait_results_drained();
        send_request(OP_CLEAR, 6'($urandom_range(0, 63)), $urandom);
        sent++;
      end else begin
        repeat ($urandom_range(20, 60)) begin
          roll = $urandom_range(0, 99);
          val  = pick_value();
          if (roll < 30) begin
            op = OP_APPEND;
          end else if (roll < 50) begin
            op = OP_GET;
          end else if (roll < 68) begin
            op = OP_REMOVE;
          end else if (roll < 88) begin
            op = OP_FIND;
            if (shadow_len > 0 && $urandom_range(0, 9) < 7)
              val = shadow_entries[$urandom_range(0, shadow_len - 1)];
          end else if (roll < 92) begin
            op = OP_CLEAR;
          end else begin
            op = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
          end
          send_request(op, pick_index(), val);
          if (op < OP_FIRST_UNUSED) sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_append_and_get();
    test_unused_codes();
    test_find_lowest();
    test_remove_compaction();
    test_clear();
    wait_results_drained();
    test_random_traffic(1775);
    wait_results_drained();
    // room for a late get or find beat still walking the chain
    repeat (CAPACITY + 16) @(posedge clk_i);
    if (mismatch_count == 0 && pending_responses.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/olt_pkg.sv
rtl/core/olt_cell.sv
rtl/core/ordered_list_table_core.sv
rtl/core/olt_checker.sv
test/testbench.sv
